// File: rtl/core/cmpg_pkg.sv
// Package for the chirp marker pulse generator: field widths, register
// indexes and shared types. No dependencies.
package cmpg_pkg;

    localparam int CFG_CHANNELS = 2;
    localparam int IVAL_W       = 24;
    localparam int LEN_W        = 24;
    localparam int COUNT_W      = 12;
    localparam int ENABLE_W     = 2;
    localparam int OFFSET_W     = 21;
    localparam int CFG_DATA_W   = 24;
    localparam int CFG_INDEX_W  = 3;
    localparam int SAMPLE_W     = 37;
    localparam int WIN_W        = 27;
    localparam int BASE_W       = 26;
    localparam int PROD_W       = 36;

    localparam logic [COUNT_W-1:0] NUM_MAX_INTERVAL = 12'd4095;

    localparam logic [CFG_INDEX_W-1:0] REG_INTERVAL    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CHIRP_LEN   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CHIRP_COUNT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CH_ENABLE   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CH0_START   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_CH0_END     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_CH1_START   = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_CH1_END     = 3'd7;

    typedef logic signed [OFFSET_W-1:0] offset_t;
    typedef logic signed [WIN_W-1:0]    window_t;

endpackage

// File: rtl/core/chirp_marker_pulse_generator.sv
// Chirp marker pulse generator: one marker word per sample tick for a chirp train.
// Depends on cmpg_pkg.
//
//  channel  | signals                               | direction
//  ---------+---------------------------------------+----------
//  cfg      | cfg_write_en, cfg_index, cfg_data     | in
//  tick in  | in_valid, restart / in_stall          | in / out
//  marker   | out_stall / out_valid, marker_bits,   | in / out
//           | last_sample, pattern_done             |
//
// One item per clock while out_stall is low; each item passes the input register, then the result register.
// Derived timing (lead/tail sum, chirp train product, windows) is registered in the
// cycle after a config write. After reset the pattern starts at sample zero.
// in_stall follows out_stall only while both stages hold an item.
module chirp_marker_pulse_generator #(
    parameter int NUM_CHANNELS = 2
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_en,
    input  logic [cmpg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cmpg_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             restart,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [NUM_CHANNELS-1:0]          marker_bits,
    output logic                             last_sample,
    output logic                             pattern_done
);

    import cmpg_pkg::*;

    // configuration
    logic [IVAL_W-1:0]   interval_reg;
    logic [LEN_W-1:0]    chirp_len_reg;
    logic [COUNT_W-1:0]  chirp_count_reg;
    logic [ENABLE_W-1:0] channel_enable_reg;
    offset_t             start_off_reg [CFG_CHANNELS];
    offset_t             end_off_reg   [CFG_CHANNELS];

    // derived timing
    logic [OFFSET_W:0]   lead;
    logic [OFFSET_W-1:0] tail;
    logic [IVAL_W-1:0]   ival;
    logic [COUNT_W-1:0]  count_m1;
    logic [BASE_W-1:0]   base_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic                empty_reg;
    logic [CFG_CHANNELS-1:0] en_reg;
    window_t             lo_reg [CFG_CHANNELS];
    window_t             hi_reg [CFG_CHANNELS];

    // pattern state
    logic [SAMPLE_W-1:0] idx_reg;
    logic [IVAL_W-1:0]   pos_reg;
    logic [COUNT_W-1:0]  num_reg;
    logic                fin_reg;

    // pipeline
    logic                in_valid_reg;
    logic                restart_reg;
    logic                out_valid_reg;
    logic [NUM_CHANNELS-1:0] marker_reg;
    logic                last_reg;
    logic                done_reg;

    logic                advance;
    logic                fire;
    logic [SAMPLE_W-1:0] idx_cur;
    logic [IVAL_W-1:0]   pos_cur;
    logic [COUNT_W-1:0]  num_cur;
    logic                fin_cur;
    logic [SAMPLE_W-1:0] total;
    logic [SAMPLE_W-1:0] idx_inc;
    logic [IVAL_W:0]     pos_inc;
    logic                done;
    logic                last;
    logic                active;
    window_t             pos_w;
    logic [NUM_CHANNELS-1:0] marker_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg       <= IVAL_W'(1);
            chirp_len_reg      <= '0;
            chirp_count_reg    <= '0;
            channel_enable_reg <= '0;
            for (int ch = 0; ch < CFG_CHANNELS; ch++)
            begin
                start_off_reg[ch] <= '0;
                end_off_reg[ch]   <= '0;
            end
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_INTERVAL:    interval_reg       <= cfg_data[IVAL_W-1:0];
                REG_CHIRP_LEN:   chirp_len_reg      <= cfg_data[LEN_W-1:0];
                REG_CHIRP_COUNT: chirp_count_reg    <= cfg_data[COUNT_W-1:0];
                REG_CH_ENABLE:   channel_enable_reg <= cfg_data[ENABLE_W-1:0];
                REG_CH0_START:   start_off_reg[0]   <= offset_t'(cfg_data[OFFSET_W-1:0]);
                REG_CH0_END:     end_off_reg[0]     <= offset_t'(cfg_data[OFFSET_W-1:0]);
                REG_CH1_START:   start_off_reg[1]   <= offset_t'(cfg_data[OFFSET_W-1:0]);
                REG_CH1_END:     end_off_reg[1]     <= offset_t'(cfg_data[OFFSET_W-1:0]);
            endcase
        end
    end

    // lead = largest negated start offset, tail = largest end offset, over enabled channels, both >= 0
    always_comb
    begin
        logic signed [OFFSET_W:0] neg_start;
        lead = '0;
        tail = '0;
        for (int ch = 0; ch < CFG_CHANNELS; ch++)
        begin
            neg_start = -($signed({start_off_reg[ch][OFFSET_W-1], start_off_reg[ch]}));
            if (ch < NUM_CHANNELS && channel_enable_reg[ch])
            begin
                if (neg_start > $signed(lead))
                begin
                    lead = $unsigned(neg_start);
                end
                if (end_off_reg[ch] > $signed(tail))
                begin
                    tail = $unsigned(end_off_reg[ch]);
                end
            end
        end
    end

    assign ival     = (interval_reg == '0) ? IVAL_W'(1) : interval_reg;
    assign count_m1 = chirp_count_reg - COUNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_reg <= 1'b1;
            en_reg    <= '0;
        end
        else
        begin
            empty_reg <= (chirp_count_reg == '0);
            for (int ch = 0; ch < CFG_CHANNELS; ch++)
            begin
                en_reg[ch] <= (ch < NUM_CHANNELS) && channel_enable_reg[ch];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= BASE_W'(lead) + BASE_W'(tail) + BASE_W'(chirp_len_reg);
        prod_reg <= PROD_W'(count_m1) * PROD_W'(ival);
        for (int ch = 0; ch < CFG_CHANNELS; ch++)
        begin
            lo_reg[ch] <= $signed(WIN_W'(lead)) + window_t'(start_off_reg[ch]);
            hi_reg[ch] <= $signed(WIN_W'(lead)) + $signed(WIN_W'(chirp_len_reg))
                        + window_t'(end_off_reg[ch]) - window_t'(1);
        end
    end

    // handshake
    assign advance   = !out_valid_reg || !out_stall;
    assign fire      = in_valid_reg && advance;
    assign in_stall  = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            restart_reg <= restart;
        end
    end

    // per-sample evaluation
    assign idx_cur = restart_reg ? '0 : idx_reg;
    assign pos_cur = restart_reg ? '0 : pos_reg;
    assign num_cur = restart_reg ? '0 : num_reg;
    assign fin_cur = restart_reg ? 1'b0 : fin_reg;

    assign total   = empty_reg ? '0 : SAMPLE_W'(base_reg) + SAMPLE_W'(prod_reg);
    assign idx_inc = idx_cur + SAMPLE_W'(1);
    assign pos_inc = {1'b0, pos_cur} + (IVAL_W+1)'(1);
    assign done    = fin_cur || (idx_cur >= total);
    assign last    = !done && (idx_inc == total);
    assign active  = !done && (num_cur < chirp_count_reg);
    assign pos_w   = $signed(WIN_W'(pos_cur));

    for (genvar n = 0; n < NUM_CHANNELS; n++)
    begin : g_marker
        if (n < CFG_CHANNELS)
        begin : g_cfg
            assign marker_next[n] = active && en_reg[n]
                                  && (pos_w >= lo_reg[n]) && (pos_w <= hi_reg[n]);
        end
        else
        begin : g_none
            assign marker_next[n] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            pos_reg <= '0;
            num_reg <= '0;
            fin_reg <= 1'b0;
        end
        else if (fire)
        begin
            if (done)
            begin
                idx_reg <= idx_cur;
                pos_reg <= pos_cur;
                num_reg <= num_cur;
                fin_reg <= 1'b1;
            end
            else
            begin
                idx_reg <= idx_inc;
                fin_reg <= 1'b0;
                if (pos_inc >= {1'b0, ival})
                begin
                    pos_reg <= '0;
                    num_reg <= (num_cur < NUM_MAX_INTERVAL) ? num_cur + COUNT_W'(1)
                                                            : num_cur;
                end
                else
                begin
                    pos_reg <= pos_inc[IVAL_W-1:0];
                    num_reg <= num_cur;
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            marker_reg <= marker_next;
            last_reg   <= last;
            done_reg   <= done;
        end
    end

    assign out_valid    = out_valid_reg;
    assign marker_bits  = marker_reg;
    assign last_sample  = last_reg;
    assign pattern_done = done_reg;

endmodule
